// ===== rtl/scoped_symbol_table_defines.svh =====
// Assertion macros shared by the symbol table RTL.
// Synthesis builds see empty bodies.
`ifndef SCOPED_SYMBOL_TABLE_DEFINES_SVH
`define SCOPED_SYMBOL_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define SST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("symbol table assertion failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define SST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("symbol table assertion failed");
`else
`define SST_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SST_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/sst_pkg.sv =====
package sst_pkg;

	// Table geometry.
	localparam int SYMBOL_SLOTS = 512;
	localparam int TABLE_SLOTS  = 1024;
	localparam int MAX_SCOPE    = 511;

	// Field widths of the request and response.
	localparam int OP_W     = 3;
	localparam int NAME_W   = 64;
	localparam int SLOT_W   = 10;
	localparam int STATUS_W = 2;
	localparam int ADDR_W   = $clog2(SYMBOL_SLOTS);
	localparam int NAME_BYTES = 16;

	// Operation codes.
	typedef enum logic [OP_W-1:0] {
		OP_PUSH     = 3'd0,
		OP_LOOKUP   = 3'd1,
		OP_ENTER    = 3'd2,
		OP_LEAVE    = 3'd3,
		OP_PUSH_TMP = 3'd4,
		OP_POP_TMP  = 3'd5
	} op_t;

	// Response status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_LOOK,
		S_LEAVE,
		S_DONE
	} state_t;

	// One entry of the symbol memory.
	typedef struct packed {
		logic [NAME_W-1:0] name_high;
		logic [NAME_W-1:0] name_low;
		logic              is_const;
		logic [SLOT_W-1:0] scope;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic ready;
		logic exec;
		logic look_start;
		logic look_step;
		logic leave_start;
		logic leave_step;
		logic emit;
	} sst_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_valid;
		op_t  op;
		logic scope_neg;
		logic look_done;
		logic leave_done;
		logic out_free;
	} sst_stat_t;

endpackage

// ===== rtl/sst_if.sv =====
// Request channel: one operation with its name and const mark.
interface sst_req_if;
	logic                        valid;
	logic                        ready;
	logic [sst_pkg::OP_W-1:0]    op;
	logic [sst_pkg::NAME_W-1:0]  name_high;
	logic [sst_pkg::NAME_W-1:0]  name_low;
	logic                        is_const;

	modport source (output valid, op, name_high, name_low, is_const, input ready);
	modport sink (input valid, op, name_high, name_low, is_const, output ready);
endinterface

// Response channel: one result per request.
interface sst_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [sst_pkg::STATUS_W-1:0]  status;
	logic [sst_pkg::SLOT_W-1:0]    slot_index;
	logic [sst_pkg::SLOT_W-1:0]    symbol_count;
	logic signed [sst_pkg::SLOT_W-1:0] scope_level;

	modport source (output valid, status, slot_index, symbol_count, scope_level, input ready);
	modport sink (input valid, status, slot_index, symbol_count, scope_level, output ready);
endinterface

// ===== rtl/sst_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
module sst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/sst_ctrl.sv =====
// Sequencer: takes a request, dispatches it, runs the scans and hands off the result.
module sst_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  sst_pkg::sst_stat_t stat,
	output sst_pkg::sst_cmd_t  cmd
);

	sst_pkg::state_t state_q;
	sst_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sst_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			sst_pkg::S_IDLE: begin
				cmd.ready = 1'b1;
				if (stat.in_valid) begin
					state_d = sst_pkg::S_EXEC;
				end
			end
			sst_pkg::S_EXEC: begin
				unique case (stat.op)
					sst_pkg::OP_LOOKUP: begin
						cmd.look_start = 1'b1;
						state_d        = sst_pkg::S_LOOK;
					end
					sst_pkg::OP_LEAVE: begin
						if (stat.scope_neg) begin
							cmd.exec = 1'b1;
							state_d  = sst_pkg::S_DONE;
						end else begin
							cmd.leave_start = 1'b1;
							state_d         = sst_pkg::S_LEAVE;
						end
					end
					default: begin
						cmd.exec = 1'b1;
						state_d  = sst_pkg::S_DONE;
					end
				endcase
			end
			sst_pkg::S_LOOK: begin
				cmd.look_step = 1'b1;
				if (stat.look_done) begin
					state_d = sst_pkg::S_DONE;
				end
			end
			sst_pkg::S_LEAVE: begin
				cmd.leave_step = 1'b1;
				if (stat.leave_done) begin
					state_d = sst_pkg::S_DONE;
				end
			end
			sst_pkg::S_DONE: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = sst_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sst_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/sst_dp.sv =====
// Datapath: request registers, stack pointers, symbol memory, name compare and
// the response register.
module sst_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  sst_pkg::sst_cmd_t  cmd,
	output sst_pkg::sst_stat_t stat,
	sst_req_if.sink            req,
	sst_rsp_if.source          rsp
);

	localparam int SW = sst_pkg::SLOT_W;
	localparam int AW = sst_pkg::ADDR_W;

	// Latched request.
	sst_pkg::op_t              op_q;
	logic [sst_pkg::NAME_W-1:0] name_high_q;
	logic [sst_pkg::NAME_W-1:0] name_low_q;
	logic                      is_const_q;

	// Stack pointers and scope depth.
	logic [SW-1:0] top_q, top_d;
	logic [SW-1:0] temp_q, temp_d;
	logic [SW-1:0] scope_q, scope_d;

	// Scan pointer and the entry whose read data is due this cycle.
	logic [SW-1:0] scan_q, scan_d, scan_dec;
	logic          pend_q, pend_d;
	logic [AW-1:0] pend_idx_q, pend_idx_d;

	// Result of the current request.
	sst_pkg::status_t res_status_q, res_status_d;
	logic [SW-1:0]    res_slot_q, res_slot_d;
	logic             res_load;

	// Response register.
	logic                        out_valid_q;
	logic [sst_pkg::STATUS_W-1:0] out_status_q;
	logic [SW-1:0]               out_slot_q;
	logic [SW-1:0]               out_count_q;
	logic [SW-1:0]               out_level_q;

	// Memory ports.
	logic            ram_we, ram_re;
	logic [AW-1:0]   ram_waddr, ram_raddr;
	sst_pkg::entry_t ram_wdata, ram_rdata;

	// Compare and scan conditions.
	logic [8*sst_pkg::NAME_BYTES-1:0] key_name, stored_name;
	logic [7:0] key_byte, stored_byte;
	logic       live, mismatch;
	logic       name_hit, look_more, look_done;
	logic       scope_eq, leave_stop, leave_more, leave_done;
	logic       push_full, enter_full, tmp_full, tmp_empty;
	logic       load;

	assign load = req.valid && cmd.ready;
	assign req.ready = cmd.ready;

	sst_ram #(
		.WIDTH(sst_pkg::ENTRY_W),
		.DEPTH(sst_pkg::SYMBOL_SLOTS)
	) u_sym_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Name compare: bytes must agree up to and including the stored name's first zero.
	assign key_name    = {name_high_q, name_low_q};
	assign stored_name = {ram_rdata.name_high, ram_rdata.name_low};

	always_comb begin
		live     = 1'b1;
		mismatch = 1'b0;
		key_byte = '0;
		stored_byte = '0;
		for (int k = 0; k < sst_pkg::NAME_BYTES; k++) begin
			key_byte    = key_name[8*(sst_pkg::NAME_BYTES-k)-1 -: 8];
			stored_byte = stored_name[8*(sst_pkg::NAME_BYTES-k)-1 -: 8];
			if (live && (key_byte != stored_byte)) begin
				mismatch = 1'b1;
			end
			if (stored_byte == 8'd0) begin
				live = 1'b0;
			end
		end
	end

	// Scan conditions for lookup (upward) and scope exit (downward).
	assign scan_dec   = scan_q - SW'(1);
	assign name_hit   = pend_q && !mismatch;
	assign look_more  = scan_q < top_q;
	assign look_done  = name_hit || (!look_more && !pend_q);
	assign scope_eq   = ram_rdata.scope == scope_q;
	assign leave_stop = pend_q && !scope_eq;
	assign leave_more = (scan_q != '0) && !leave_stop;
	assign leave_done = leave_stop || (!pend_q && (scan_q == '0));

	// Limit checks for push, enter and the temporary-slot operations.
	assign push_full  = top_q >= SW'(sst_pkg::SYMBOL_SLOTS);
	assign enter_full = $signed(scope_q) >= $signed(SW'(sst_pkg::MAX_SCOPE));
	assign tmp_full   = temp_q >= SW'(sst_pkg::TABLE_SLOTS - 1);
	assign tmp_empty  = temp_q < SW'(sst_pkg::SYMBOL_SLOTS);

	// Memory write for a push, reads for the scans.
	assign ram_we              = cmd.exec && (op_q == sst_pkg::OP_PUSH) && !push_full;
	assign ram_waddr           = top_q[AW-1:0];
	assign ram_wdata.name_high = name_high_q;
	assign ram_wdata.name_low  = name_low_q;
	assign ram_wdata.is_const  = is_const_q;
	assign ram_wdata.scope     = scope_q;
	assign ram_re    = (cmd.look_step && !name_hit && look_more) ||
			   (cmd.leave_step && leave_more);
	assign ram_raddr = cmd.leave_step ? scan_dec[AW-1:0] : scan_q[AW-1:0];

	// Next-state logic of pointers, scan and result.
	always_comb begin
		top_d        = top_q;
		temp_d       = temp_q;
		scope_d      = scope_q;
		scan_d       = scan_q;
		pend_d       = pend_q;
		pend_idx_d   = pend_idx_q;
		res_load     = 1'b0;
		res_status_d = sst_pkg::ST_OK;
		res_slot_d   = '0;

		if (cmd.exec) begin
			res_load = 1'b1;
			unique case (op_q)
				sst_pkg::OP_PUSH: begin
					if (push_full) begin
						res_status_d = sst_pkg::ST_FULL;
					end else begin
						res_slot_d = top_q;
						top_d      = top_q + SW'(1);
					end
				end
				sst_pkg::OP_ENTER: begin
					if (enter_full) begin
						res_status_d = sst_pkg::ST_FULL;
					end else begin
						scope_d = scope_q + SW'(1);
					end
				end
				sst_pkg::OP_LEAVE: begin
					res_status_d = sst_pkg::ST_EMPTY;
				end
				sst_pkg::OP_PUSH_TMP: begin
					if (tmp_full) begin
						res_status_d = sst_pkg::ST_FULL;
					end else begin
						temp_d     = temp_q + SW'(1);
						res_slot_d = temp_q + SW'(1);
					end
				end
				sst_pkg::OP_POP_TMP: begin
					if (tmp_empty) begin
						res_status_d = sst_pkg::ST_EMPTY;
					end else begin
						res_slot_d = temp_q;
						temp_d     = temp_q - SW'(1);
					end
				end
				default: begin
					res_status_d = sst_pkg::ST_OK;
				end
			endcase
		end

		if (cmd.look_start) begin
			scan_d = '0;
			pend_d = 1'b0;
		end

		if (cmd.leave_start) begin
			scan_d = top_q;
			pend_d = 1'b0;
		end

		// Lookup: compare the entry read last cycle while reading the next one.
		if (cmd.look_step) begin
			if (name_hit) begin
				res_load   = 1'b1;
				res_slot_d = SW'(pend_idx_q);
				pend_d     = 1'b0;
			end else if (look_more) begin
				pend_d     = 1'b1;
				pend_idx_d = scan_q[AW-1:0];
				scan_d     = scan_q + SW'(1);
			end else if (pend_q) begin
				pend_d = 1'b0;
			end else begin
				res_load     = 1'b1;
				res_status_d = sst_pkg::ST_MISSING;
			end
		end

		// Scope exit: pop the top entry while its depth equals the current one.
		if (cmd.leave_step) begin
			if (pend_q && scope_eq) begin
				top_d = SW'(pend_idx_q);
			end
			if (leave_done) begin
				res_load = 1'b1;
				scope_d  = scope_q - SW'(1);
				pend_d   = 1'b0;
			end else if (leave_more) begin
				pend_d     = 1'b1;
				pend_idx_d = scan_dec[AW-1:0];
				scan_d     = scan_dec;
			end else begin
				pend_d = 1'b0;
			end
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q       <= '0;
			temp_q      <= SW'(sst_pkg::SYMBOL_SLOTS - 1);
			scope_q     <= '1;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			top_q   <= top_d;
			temp_q  <= temp_d;
			scope_q <= scope_d;
			pend_q  <= pend_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (load) begin
			op_q        <= sst_pkg::op_t'(req.op);
			name_high_q <= req.name_high;
			name_low_q  <= req.name_low;
			is_const_q  <= req.is_const;
		end
		scan_q     <= scan_d;
		pend_idx_q <= pend_idx_d;
		if (res_load) begin
			res_status_q <= res_status_d;
			res_slot_q   <= res_slot_d;
		end
		if (cmd.emit) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_count_q  <= top_q;
			out_level_q  <= scope_q;
		end
	end

	// Response port.
	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.slot_index   = out_slot_q;
	assign rsp.symbol_count = out_count_q;
	assign rsp.scope_level  = $signed(out_level_q);

	// Status to the controller.
	assign stat.in_valid   = req.valid;
	assign stat.op         = op_q;
	assign stat.scope_neg  = scope_q[SW-1];
	assign stat.look_done  = look_done;
	assign stat.leave_done = leave_done;
	assign stat.out_free   = !out_valid_q || rsp.ready;

endmodule

// ===== rtl/scoped_symbol_table.sv =====
// Scoped symbol table with a symbol stack and a temporary-slot stack.
// The req channel carries one operation per request (push symbol, lookup,
// enter scope, leave scope, push temp, pop temp) with a 16-byte name and a
// const mark; the rsp channel returns exactly one result per request with
// status, slot index, symbol count and scope depth, in request order.
// Both channels move a request when valid and ready are high at a clock edge.
// One request is worked on at a time. Push, enter, the temporary operations
// and a leave outside all scopes run without a scan of the symbol memory.
// Lookup reads the symbol memory one entry per cycle from the bottom and stops
// at the first entry whose name matches, or reports the name missing when all
// stored entries miss; leave scope reads downward from the top, one entry per
// cycle, and pops the entries of the current depth. The next request can be
// accepted in the cycle after a result is loaded into the response register.
// Reset clears the pointers (no symbols, no temporaries, outside all scopes);
// the memory is not cleared and the block is ready at once. While the receiver
// stalls, the result stays in the response register and one more request may
// be taken and worked on; its result waits until the register is free.
`include "scoped_symbol_table_defines.svh"

module scoped_symbol_table (
	input logic       clk,
	input logic       arst_n,
	sst_req_if.sink   req,
	sst_rsp_if.source rsp
);

	sst_pkg::sst_cmd_t  cmd;
	sst_pkg::sst_stat_t stat;

	// Sequencer.
	sst_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.stat  (stat),
		.cmd   (cmd)
	);

	// Storage, compare and response register.
	sst_dp u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.stat  (stat),
		.req   (req),
		.rsp   (rsp)
	);

	// The symbol count never exceeds the stack size.
	`SST_ASSERT_IMP(a_count_bound, clk, arst_n, rsp.valid, rsp.symbol_count <= 10'(sst_pkg::SYMBOL_SLOTS))
	// A failed request reports slot zero.
	`SST_ASSERT_IMP(a_slot_zero, clk, arst_n, rsp.valid && (rsp.status != sst_pkg::ST_OK), rsp.slot_index == '0)
	// Only one request is in work at a time.
	`SST_ASSERT_NXT(a_one_req, clk, arst_n, req.valid && req.ready, !req.ready)

endmodule

// ===== sim/scoped_symbol_table_tb.sv =====
`timescale 1ns / 100ps

module scoped_symbol_table_tb;
	import sst_pkg::*;

	localparam int POOL_SIZE = 8;
	localparam int TAIL_CYCLES = 40;
	localparam longint TIMEOUT_NS = 64'd50_000_000;

	// Operation codes that the block does not define.
	localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

	localparam logic [127:0] NAME_ONES = {128{1'b1}};
	localparam logic [127:0] NAME_NONE = '0;
	localparam logic [127:0] NAME_B = 128'h6D61_696E_0000_0000_0000_0000_0000_0000;

	// One response as the table should produce it.
	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot;
		logic [SLOT_W-1:0] count;
		logic [SLOT_W-1:0] level;
	} answer_t;

	// Shadow copy of the symbol table and the queue of responses it predicts.
	class symbol_table_shadow;
		logic [127:0] stored_name [SYMBOL_SLOTS];
		int           stored_scope [SYMBOL_SLOTS];
		int           symbols;
		int           temp_top;
		int           depth;
		answer_t      answers_due [$];
		int           requests;
		int           checked;
		int           errors;

		function new();
			symbols = 0;
			temp_top = SYMBOL_SLOTS - 1;
			depth = -1;
			requests = 0;
			checked = 0;
			errors = 0;
		endfunction

		// Names compare up to and including the first zero byte of the stored name.
		function bit names_equal(logic [127:0] held, logic [127:0] query);
			logic [7:0] a;
			logic [7:0] b;
			int k;
			for (k = 0; k < NAME_BYTES; k++) begin
				a = held[127-8*k -: 8];
				b = query[127-8*k -: 8];
				if (a != b)
					return 1'b0;
				if (a == 8'h00)
					return 1'b1;
			end
			return 1'b1;
		endfunction

		// Update the shadow state for an accepted request and queue its answer.
		function void apply_request(logic [OP_W-1:0] op, logic [127:0] nm, logic cst);
			answer_t r;
			int i;
			requests++;
			r.status = ST_OK;
			r.slot = '0;
			case (op)
				OP_PUSH: begin
					if (symbols >= SYMBOL_SLOTS) begin
						r.status = ST_FULL;
					end else begin
						stored_name[symbols] = nm;
						stored_scope[symbols] = depth;
						r.slot = SLOT_W'(symbols);
						symbols++;
					end
				end
				OP_LOOKUP: begin
					r.status = ST_MISSING;
					for (i = 0; i < symbols && r.status == ST_MISSING; i++) begin
						if (names_equal(stored_name[i], nm)) begin
							r.status = ST_OK;
							r.slot = SLOT_W'(i);
						end
					end
				end
				OP_ENTER: begin
					if (depth >= MAX_SCOPE)
						r.status = ST_FULL;
					else
						depth++;
				end
				OP_LEAVE: begin
					if (depth < 0) begin
						r.status = ST_EMPTY;
					end else begin
						while (symbols > 0 && stored_scope[symbols-1] == depth)
							symbols--;
						depth--;
					end
				end
				OP_PUSH_TMP: begin
					if (temp_top >= TABLE_SLOTS - 1) begin
						r.status = ST_FULL;
					end else begin
						temp_top++;
						r.slot = SLOT_W'(temp_top);
					end
				end
				OP_POP_TMP: begin
					if (temp_top < SYMBOL_SLOTS) begin
						r.status = ST_EMPTY;
					end else begin
						r.slot = SLOT_W'(temp_top);
						temp_top--;
					end
				end
				default: begin
				end
			endcase
			r.count = SLOT_W'(symbols);
			r.level = SLOT_W'(depth);
			answers_due.push_back(r);
		endfunction

		// Compare one accepted response with the oldest predicted answer.
		function void check_result(logic [STATUS_W-1:0] st, logic [SLOT_W-1:0] slot,
				logic [SLOT_W-1:0] cnt, logic [SLOT_W-1:0] lvl);
			answer_t want;
			checked++;
			if (answers_due.size() == 0) begin
				errors++;
				$display("%0t: expected no response, got status %0d slot %0d count %0d scope %0d",
					$time, st, slot, cnt, $signed(lvl));
				return;
			end
			want = answers_due.pop_front();
			if (want.status !== st || want.slot !== slot || want.count !== cnt ||
					want.level !== lvl) begin
				errors++;
				$display("%0t: expected status %0d slot %0d count %0d scope %0d, got %0d %0d %0d %0d",
					$time, want.status, want.slot, want.count, $signed(want.level),
					st, slot, cnt, $signed(lvl));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   calm;

	symbol_table_shadow board;

	logic [127:0] pool_name [POOL_SIZE];
	int           pool_len [POOL_SIZE];

	sst_req_if req_ch ();
	sst_rsp_if rsp_ch ();

	scoped_symbol_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Idle cycles before the next request or response; none in calm stretches.
	function automatic int pause_length();
		return calm ? 0 : int'($urandom_range(0, 10));
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// A name of len nonzero bytes, a terminating zero, then arbitrary bytes.
	function automatic logic [127:0] make_name(int len);
		logic [127:0] nm;
		int k;
		for (k = 0; k < NAME_BYTES; k++) begin
			if (k < len)
				nm[127-8*k -: 8] = 8'($urandom_range(1, 255));
			else if (k == len)
				nm[127-8*k -: 8] = 8'h00;
			else
				nm[127-8*k -: 8] = 8'($urandom_range(0, 255));
		end
		return nm;
	endfunction

	// A lookup key derived from a known name: exact, new tail, one byte off, or random.
	function automatic logic [127:0] name_variant(logic [127:0] base, int len);
		logic [127:0] nm;
		int k;
		nm = base;
		case ($urandom_range(0, 3))
			0: begin
			end
			1: begin
				for (k = len + 1; k < NAME_BYTES; k++)
					nm[127-8*k -: 8] = 8'($urandom_range(0, 255));
			end
			2: begin
				if (len > 0) begin
					k = $urandom_range(0, len - 1);
					nm[127-8*k -: 8] = base[127-8*k -: 8] ^ 8'($urandom_range(1, 255));
				end
			end
			default: nm = {rand64(), rand64()};
		endcase
		return nm;
	endfunction

	// Present one request and hold it until the table takes it.
	task automatic send_request(input logic [OP_W-1:0] op, input logic [127:0] nm,
			input logic cst);
		int gap;
		gap = pause_length();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.name_high <= nm[127:64];
		req_ch.name_low <= nm[63:0];
		req_ch.is_const <= cst;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		board.apply_request(op, nm, cst);
	endtask

	// Hold off new requests until every outstanding response is back.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (board.answers_due.size() != 0);
	endtask

	// Short directed sequence over the empty, matching and scoping corners.
	task automatic directed_checks();
		send_request(OP_POP_TMP, NAME_NONE, 1'b0);
		send_request(OP_LEAVE, NAME_NONE, 1'b0);
		send_request(OP_LOOKUP, NAME_ONES, 1'b0);
		send_request(OP_PUSH, NAME_ONES, 1'b1);
		send_request(OP_LOOKUP, NAME_ONES, 1'b0);
		send_request(OP_LOOKUP, {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE}, 1'b0);
		// Bytes past the terminating zero must not take part in the match.
		send_request(OP_PUSH, 128'h6162_00FF_1234_5678_9ABC_DEF0_0102_0304, 1'b0);
		send_request(OP_LOOKUP, 128'h6162_0000_0000_0000_0000_0000_0000_0000, 1'b1);
		send_request(OP_LOOKUP, 128'h6163_00FF_1234_5678_9ABC_DEF0_0102_0304, 1'b0);
		send_request(OP_PUSH, NAME_NONE, 1'b1);
		send_request(OP_LOOKUP, 128'h00AB_CDEF_0123_4567_89AB_CDEF_0123_4567, 1'b0);
		// A shadowing name in a nested scope; lookup must return the lower one.
		send_request(OP_ENTER, NAME_NONE, 1'b0);
		send_request(OP_PUSH, NAME_B, 1'b0);
		send_request(OP_ENTER, NAME_NONE, 1'b0);
		send_request(OP_PUSH, NAME_B, 1'b1);
		send_request(OP_LOOKUP, NAME_B, 1'b0);
		send_request(OP_LEAVE, NAME_NONE, 1'b0);
		send_request(OP_LEAVE, NAME_NONE, 1'b0);
		send_request(OP_PUSH_TMP, NAME_NONE, 1'b0);
		send_request(OP_PUSH_TMP, NAME_NONE, 1'b0);
		send_request(OP_POP_TMP, NAME_NONE, 1'b0);
		send_request(OP_POP_TMP, NAME_NONE, 1'b0);
		send_request(OP_POP_TMP, NAME_NONE, 1'b0);
		send_request(OP_UNUSED_6, NAME_ONES, 1'b1);
		send_request(OP_UNUSED_7, NAME_NONE, 1'b0);
	endtask

	// Drive every stack to its limit and past it, then empty the scope and temporary stacks again.
	task automatic fill_checks();
		calm = 1'b1;
		repeat (MAX_SCOPE + 2)
			send_request(OP_ENTER, {rand64(), rand64()}, 1'($urandom));
		repeat (MAX_SCOPE + 2)
			send_request(OP_LEAVE, {rand64(), rand64()}, 1'($urandom));
		repeat (TABLE_SLOTS - SYMBOL_SLOTS + 1)
			send_request(OP_PUSH_TMP, {rand64(), rand64()}, 1'($urandom));
		repeat (TABLE_SLOTS - SYMBOL_SLOTS + 1)
			send_request(OP_POP_TMP, {rand64(), rand64()}, 1'($urandom));
		calm = 1'b0;
		wait_drained();

		// Full symbol stack, long scans, and one leave that pops most of it.
		send_request(OP_ENTER, NAME_NONE, 1'b0);
		while (board.symbols < SYMBOL_SLOTS)
			send_request(OP_PUSH, {rand64(), rand64()}, 1'($urandom));
		send_request(OP_PUSH, NAME_ONES, 1'b1);
		send_request(OP_LOOKUP, board.stored_name[SYMBOL_SLOTS-1], 1'b0);
		send_request(OP_LOOKUP, {rand64(), rand64()}, 1'b0);
		send_request(OP_LOOKUP, NAME_ONES, 1'b0);
		send_request(OP_LEAVE, NAME_NONE, 1'b0);
		wait_drained();
	endtask

	// Mostly well-formed scope blocks over a small name pool, mixed with noise.
	task automatic random_traffic(input int target);
		int sent;
		int kind;
		int steps;
		int j;
		int pick;
		int choice;
		sent = 0;
		for (j = 0; j < POOL_SIZE; j++) begin
			pool_len[j] = $urandom_range(0, NAME_BYTES);
			pool_name[j] = make_name(pool_len[j]);
		end
		while (sent < target) begin
			calm = ($urandom_range(0, 5) == 0);
			kind = $urandom_range(0, 9);
			if (kind <= 6) begin
				send_request(OP_ENTER, {rand64(), rand64()}, 1'($urandom));
				sent++;
				steps = $urandom_range(1, 6);
				for (j = 0; j < steps; j++) begin
					choice = $urandom_range(0, 9);
					pick = $urandom_range(0, POOL_SIZE - 1);
					if (choice < 4)
						send_request(OP_PUSH, pool_name[pick], 1'($urandom));
					else if (choice < 7)
						send_request(OP_LOOKUP, name_variant(pool_name[pick],
							pool_len[pick]), 1'($urandom));
					else if (choice < 8)
						send_request(OP_PUSH_TMP, {rand64(), rand64()}, 1'($urandom));
					else if (choice < 9)
						send_request(OP_POP_TMP, {rand64(), rand64()}, 1'($urandom));
					else
						send_request(OP_ENTER, {rand64(), rand64()}, 1'($urandom));
					sent++;
				end
				if ($urandom_range(0, 4) != 0 || board.depth > 12) begin
					send_request(OP_LEAVE, {rand64(), rand64()}, 1'($urandom));
					sent++;
				end
			end else if (kind <= 8) begin
				send_request(OP_W'($urandom_range(0, 7)), {rand64(), rand64()},
					1'($urandom));
				sent++;
			end else begin
				// Unbalanced closers and stray pops.
				if ($urandom_range(0, 1) == 0)
					send_request(OP_LEAVE, {rand64(), rand64()}, 1'($urandom));
				else
					send_request(OP_POP_TMP, {rand64(), rand64()}, 1'($urandom));
				sent++;
			end
		end
		calm = 1'b0;
	endtask

	// Response side: random stalls, then check each accepted response.
	initial begin
		int stall;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = pause_length();
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (rsp_ch.valid !== 1'b1);
			board.check_result(rsp_ch.status, rsp_ch.slot_index, rsp_ch.symbol_count,
				rsp_ch.scope_level);
		end
	end

	// Request side and end of run.
	initial begin
		board = new();
		calm = 1'b0;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.op <= OP_PUSH;
		req_ch.name_high <= '0;
		req_ch.name_low <= '0;
		req_ch.is_const <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_checks();
		wait_drained();
		fill_checks();
		random_traffic(500);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d requests and %0d responses: directed name matching, full and",
			board.requests, board.checked);
		$display("empty symbol, scope and temporary stacks, then random scoped traffic.");
		if (board.errors == 0 && board.answers_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#(TIMEOUT_NS);
		$display("simulation failed");
		$finish;
	end

endmodule
